// ----- rtl/vbm_pkg.sv -----
// ----------------------------------------------------------------------------
// vbm_pkg
// Types, constants and the per-group mapping table of the VRAM bank mapping
// control block.
// ----------------------------------------------------------------------------
package vbm_pkg;

  localparam int unsigned NumBanks = 9;
  localparam int unsigned BankW    = 4;
  localparam int unsigned MapW     = 4;
  localparam int unsigned SelW     = 3;
  localparam int unsigned CtrlW    = 8;
  localparam int unsigned EnBit    = 7;

  typedef enum logic [MapW-1:0] {
    MAP_UNMAPPED    = 4'd0,
    MAP_LCDC        = 4'd1,
    MAP_A_BG        = 4'd2,
    MAP_A_OBJ       = 4'd3,
    MAP_TEXTURE     = 4'd4,
    MAP_TEX_PALETTE = 4'd5,
    MAP_EXT_BG_A    = 4'd6,
    MAP_EXT_OBJ_A   = 4'd7,
    MAP_B_BG        = 4'd8,
    MAP_EXT_BG_B    = 4'd9,
    MAP_B_OBJ       = 4'd10,
    MAP_EXT_OBJ_B   = 4'd11
  } map_e;

  typedef struct packed {
    logic             do_write;
    logic [BankW-1:0] bank;
    logic [CtrlW-1:0] control_value;
    logic [MapW-1:0]  query_target;
  } req_t;

  typedef struct packed {
    logic                bank_mapping_vld;
    logic [MapW-1:0]     bank_mapping;
    logic                bank_enabled;
    logic [NumBanks-1:0] target_mask;
  } res_t;

  // Bank write command toward the bank file
  typedef struct packed {
    logic             en;
    logic [BankW-1:0] idx;
    logic [CtrlW-1:0] value;
  } bank_wr_t;

  // Mapping selected by the low control bits, per bank group
  function automatic map_e map_lookup(input logic [BankW-1:0] bank,
                                      input logic [SelW-1:0]  sel);
    map_e code;
    code = MAP_LCDC;
    case (bank)
      4'd0, 4'd1, 4'd2, 4'd3: begin
        case (sel)
          3'd1:    code = MAP_A_BG;
          3'd2:    code = MAP_A_OBJ;
          3'd3:    code = MAP_TEXTURE;
          3'd4:    code = MAP_B_BG;
          default: code = MAP_LCDC;
        endcase
      end
      4'd4: begin
        case (sel)
          3'd1:    code = MAP_A_BG;
          3'd2:    code = MAP_A_OBJ;
          3'd3:    code = MAP_TEX_PALETTE;
          3'd4:    code = MAP_EXT_BG_A;
          default: code = MAP_LCDC;
        endcase
      end
      4'd5, 4'd6: begin
        case (sel)
          3'd1:    code = MAP_A_BG;
          3'd2:    code = MAP_A_OBJ;
          3'd3:    code = MAP_TEX_PALETTE;
          3'd4:    code = MAP_EXT_BG_A;
          3'd5:    code = MAP_EXT_OBJ_A;
          default: code = MAP_LCDC;
        endcase
      end
      4'd7: begin
        case (sel)
          3'd1:    code = MAP_B_BG;
          3'd2:    code = MAP_EXT_BG_B;
          default: code = MAP_LCDC;
        endcase
      end
      4'd8: begin
        case (sel)
          3'd1:    code = MAP_B_BG;
          3'd2:    code = MAP_B_OBJ;
          3'd3:    code = MAP_EXT_OBJ_B;
          default: code = MAP_LCDC;
        endcase
      end
      default: code = MAP_UNMAPPED;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/vbm_if.sv -----
// ----------------------------------------------------------------------------
// vbm_req_if / vbm_res_if
// Valid/ready channels for bank requests and their results.
// ----------------------------------------------------------------------------
interface vbm_req_if;
  logic       valid;
  logic       ready;
  logic       do_write;
  logic [3:0] bank;
  logic [7:0] control_value;
  logic [3:0] query_target;

  modport source (output valid, do_write, bank, control_value, query_target,
                  input ready);
  modport sink   (input valid, do_write, bank, control_value, query_target,
                  output ready);
endinterface

interface vbm_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] bank_mapping;
  logic       bank_enabled;
  logic [8:0] target_mask;

  modport source (output valid, bank_mapping, bank_enabled, target_mask,
                  input ready);
  modport sink   (input valid, bank_mapping, bank_enabled, target_mask,
                  output ready);
endinterface

// ----- rtl/vbm_bank_file.sv -----
// ----------------------------------------------------------------------------
// vbm_bank_file
// Enable bits and mapping codes of the nine banks. Also presents the bank
// state as it will be after the pending write, for same-item lookup.
// ----------------------------------------------------------------------------
module vbm_bank_file (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vbm_pkg::bank_wr_t             wr_i,
  output logic [vbm_pkg::NumBanks-1:0]  en_view_o,
  output logic [vbm_pkg::MapW-1:0]      code_view_o [vbm_pkg::NumBanks]
);

  logic [vbm_pkg::NumBanks-1:0] en_q, en_d;
  logic [vbm_pkg::MapW-1:0]     code_q [vbm_pkg::NumBanks];
  logic [vbm_pkg::MapW-1:0]     code_d [vbm_pkg::NumBanks];
  logic                         wr_en_bit;
  vbm_pkg::map_e                wr_code;

  assign wr_en_bit = wr_i.value[vbm_pkg::EnBit];
  assign wr_code   = vbm_pkg::map_lookup(wr_i.idx, wr_i.value[vbm_pkg::SelW-1:0]);

  always_comb begin
    for (int i = 0; i < vbm_pkg::NumBanks; i++) begin
      en_d[i]   = en_q[i];
      code_d[i] = code_q[i];
      if (wr_i.en && (wr_i.idx == vbm_pkg::BankW'(i))) begin
        en_d[i]   = wr_en_bit;
        // disabled bank is unmapped regardless of select
        code_d[i] = wr_en_bit ? wr_code : vbm_pkg::MAP_UNMAPPED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0;
      for (int i = 0; i < vbm_pkg::NumBanks; i++) begin
        code_q[i] <= vbm_pkg::MAP_UNMAPPED;
      end
    end else begin
      en_q <= en_d;
      for (int i = 0; i < vbm_pkg::NumBanks; i++) begin
        code_q[i] <= code_d[i];
      end
    end
  end

  assign en_view_o   = en_d;
  assign code_view_o = code_d;

endmodule

// ----- rtl/vbm_query.sv -----
// ----------------------------------------------------------------------------
// vbm_query
// Reads out the named bank and builds the mask of enabled banks that match
// the queried mapping.
// ----------------------------------------------------------------------------
module vbm_query (
  input  logic [vbm_pkg::BankW-1:0]    bank_i,
  input  logic [vbm_pkg::MapW-1:0]     query_target_i,
  input  logic [vbm_pkg::NumBanks-1:0] en_view_i,
  input  logic [vbm_pkg::MapW-1:0]     code_view_i [vbm_pkg::NumBanks],
  output vbm_pkg::res_t                res_o
);

  always_comb begin
    res_o = '0;
    for (int i = 0; i < vbm_pkg::NumBanks; i++) begin
      res_o.target_mask[i] = en_view_i[i] && (code_view_i[i] == query_target_i);
      if (bank_i == vbm_pkg::BankW'(i)) begin
        res_o.bank_mapping_vld = 1'b1;
        res_o.bank_mapping     = code_view_i[i];
        res_o.bank_enabled     = en_view_i[i];
      end
    end
  end

endmodule

// ----- rtl/vram_bank_mapping_control.sv -----
// ----------------------------------------------------------------------------
// vram_bank_mapping_control
// Path from request accept to result valid: input register, then result
// register; bank update and lookup sit between the two.
// Throughput: one item per cycle while the result register is empty or taken;
// the result register can be refilled in the cycle it is taken. Reset (async,
// active low) disables and unmaps all banks and empties both registers.
// ----------------------------------------------------------------------------
module vram_bank_mapping_control (
  input  logic           clk_i,
  input  logic           rst_ni,
  vbm_req_if.sink        req_i,
  vbm_res_if.source      res_o
);

  logic                         in_valid_q;
  vbm_pkg::req_t                in_data_q;
  logic                         out_valid_q;
  vbm_pkg::res_t                out_data_q;
  logic                         advance;
  logic                         req_fire;
  vbm_pkg::bank_wr_t            bank_wr;
  vbm_pkg::res_t                res_d;
  logic [vbm_pkg::NumBanks-1:0] en_view;
  logic [vbm_pkg::MapW-1:0]     code_view [vbm_pkg::NumBanks];

  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign req_fire    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      in_data_q.do_write      <= req_i.do_write;
      in_data_q.bank          <= req_i.bank;
      in_data_q.control_value <= req_i.control_value;
      in_data_q.query_target  <= req_i.query_target;
    end
  end

  // Writes to banks 9..15 fall through the index compare in the bank file
  assign bank_wr.en    = advance && in_data_q.do_write;
  assign bank_wr.idx   = in_data_q.bank;
  assign bank_wr.value = in_data_q.control_value;

  vbm_bank_file u_bank_file (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (bank_wr),
    .en_view_o   (en_view),
    .code_view_o (code_view)
  );

  vbm_query u_query (
    .bank_i         (in_data_q.bank),
    .query_target_i (in_data_q.query_target),
    .en_view_i      (en_view),
    .code_view_i    (code_view),
    .res_o          (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= res_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.bank_mapping = out_data_q.bank_mapping_vld ? out_data_q.bank_mapping
                                                          : vbm_pkg::MAP_UNMAPPED;
  assign res_o.bank_enabled = out_data_q.bank_enabled;
  assign res_o.target_mask  = out_data_q.target_mask;

endmodule

// ----- rtl/vbm_checker.sv -----
// ----------------------------------------------------------------------------
// vbm_checker
// Port-level checks of the VRAM bank mapping control block.
// ----------------------------------------------------------------------------
module vbm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [3:0] bank_mapping_i,
  input logic       bank_enabled_i,
  input logic [8:0] target_mask_i
);

  // no result survives reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !res_valid_i)
    else $error("result valid during reset");

  // enabled banks always carry a mapping, disabled ones never do
  a_enable_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (bank_enabled_i == (bank_mapping_i != vbm_pkg::MAP_UNMAPPED)))
    else $error("enable bit and mapping disagree");

  a_map_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (bank_mapping_i <= vbm_pkg::MAP_EXT_OBJ_B))
    else $error("mapping code out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(target_mask_i)
                                    && $stable(bank_mapping_i))
    else $error("stalled result changed");

endmodule

bind vram_bank_mapping_control vbm_checker u_vbm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .bank_mapping_i (res_o.bank_mapping),
  .bank_enabled_i (res_o.bank_enabled),
  .target_mask_i  (res_o.target_mask)
);
